// ===== rtl/cbpt_pkg.sv =====
// cbpt_pkg: shared types and constants of the cubic bezier point and tangent core
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package cbpt_pkg;

  // register map: index of each control point register (byte address 8*index)
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_CTRL1  = 2'd1;
  localparam logic [1:0] REG_CTRL2  = 2'd2;
  localparam logic [1:0] REG_END    = 2'd3;
  localparam int         ADDR_BITS  = 5;
  localparam int         DATA_BITS  = 64;
  localparam int         PT_BITS    = 63;

  // tangent format and normalization window
  localparam int         DIR_BITS   = 16;
  localparam int         DIR_ONE    = 16384;
  localparam int         NORM_BITS  = 31;
  localparam int         SMALL_LOG  = 20;

  // square root: one result bit per iteration, two iterations per stage
  localparam int         SQ_ITERS   = 32;
  localparam int         SQ_PER     = 2;
  localparam int         SQ_ST      = SQ_ITERS / SQ_PER;

  // division: fifteen quotient bits, two per stage
  localparam int         QUO_BITS   = 15;
  localparam int         DIV_PER    = 2;
  localparam int         DIV_ST     = (QUO_BITS + DIV_PER - 1) / DIV_PER;

  // pipeline control handed to every stage group
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

// ===== rtl/cbpt_casteljau.sv =====
// cbpt_casteljau: three-stage de casteljau pipeline for one coordinate axis
// depends on cbpt_pkg (pipe_ctl_t)
`timescale 1ns / 1ps

module cbpt_casteljau #(
  parameter int C = 21,
  parameter int P = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbpt_pkg::pipe_ctl_t ctl,
  input  logic [P:0]          t_i,
  input  logic signed [C-1:0] p0_i,
  input  logic signed [C-1:0] p1_i,
  input  logic signed [C-1:0] p2_i,
  input  logic signed [C-1:0] p3_i,
  output logic                vld_o,
  output logic signed [C-1:0] pos_o,
  output logic signed [C+2:0] d_o,
  output logic signed [C:0]   chord_o
);
  import cbpt_pkg::*;

  localparam int PW = C + P + 3;
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (P - 1));
  localparam logic [P:0] ONE_T = (P+1)'(1) << P;

  // a + round((b - a) * t / 2^P), half rounds up
  function automatic logic signed [C-1:0] lerp(input logic signed [C-1:0] a,
                                               input logic signed [C-1:0] b,
                                               input logic [P:0] t);
    logic signed [PW-1:0] df;
    logic signed [PW-1:0] tt;
    logic signed [PW-1:0] pr;
    df = PW'(b) - PW'(a);
    tt = $signed(PW'(t));
    pr = df * tt + HALF;
    pr = pr >>> P;
    return C'(PW'(a) + pr);
  endfunction

  logic [P:0]          t_c;
  logic [P:0]          t1_r, t2_r;
  logic signed [C-1:0] a0_r, a1_r, a2_r, p0_r, p3_r;
  logic signed [C-1:0] b0_r, b1_r;
  logic signed [C:0]   ch2_r;
  logic signed [C:0]   df3;
  logic signed [C+2:0] dx3;
  logic                v1_r, v2_r, v3_r;

  // parameters above one act as one
  assign t_c = (t_i > ONE_T) ? ONE_T : t_i;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.adv) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // derivative is three times the second-level difference
  assign df3 = (C+1)'(b1_r) - (C+1)'(b0_r);
  assign dx3 = (C+3)'(df3);

  // first, second and third interpolation levels
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      a0_r    <= lerp(p0_i, p1_i, t_c);
      a1_r    <= lerp(p1_i, p2_i, t_c);
      a2_r    <= lerp(p2_i, p3_i, t_c);
      p0_r    <= p0_i;
      p3_r    <= p3_i;
      t1_r    <= t_c;
      b0_r    <= lerp(a0_r, a1_r, t1_r);
      b1_r    <= lerp(a1_r, a2_r, t1_r);
      ch2_r   <= (C+1)'(p3_r) - (C+1)'(p0_r);
      t2_r    <= t1_r;
      pos_o   <= lerp(b0_r, b1_r, t2_r);
      d_o     <= (dx3 <<< 1) + dx3;
      chord_o <= ch2_r;
    end
  end

  assign vld_o = v3_r;

endmodule

// ===== rtl/cbpt_norm.sv =====
// cbpt_norm: short-derivative check, vector normalization, pipelined square root
// and per-lane division into a q1.14 unit tangent; depends on cbpt_pkg
`timescale 1ns / 1ps

module cbpt_norm #(
  parameter int C = 21,
  parameter int F = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbpt_pkg::pipe_ctl_t ctl,
  input  logic signed [C+2:0] d_i     [3],
  input  logic signed [C:0]   chord_i [3],
  input  logic signed [C-1:0] pos_i   [3],
  output logic                vld_o,
  output logic signed [C-1:0] pos_o   [3],
  output logic signed [cbpt_pkg::DIR_BITS-1:0] dir_o [3],
  output logic                fb_o
);
  import cbpt_pkg::*;

  localparam int DW   = C + 3;
  localparam int MW   = DW;
  localparam int SHW  = $clog2(MW);
  localparam int NB   = NORM_BITS;
  localparam int RW   = NB + QUO_BITS + 1;
  localparam logic [63:0] SHORT_SQ = 64'((64'd1 << (2 * F)) / 64'd10000);
  localparam logic signed [63:0] LIM = 64'sd1 <<< SMALL_LOG;
  // side vector: three magnitudes, signs, zero flag, fallback flag, positions
  localparam int O_SGN = 3 * NB;
  localparam int O_Z   = O_SGN + 3;
  localparam int O_FB  = O_Z + 1;
  localparam int O_POS = O_FB + 1;
  localparam int SW    = O_POS + 3 * C;

  logic adv;
  assign adv = ctl.adv;

  // ---------------- stage a: squares of short derivatives
  logic signed [DW-1:0] da_r  [3];
  logic signed [DW-1:0] cha_r [3];
  logic [41:0]          sqa_r [3];
  logic signed [C-1:0]  posa_r [3];
  logic                 sma_r;
  logic signed [63:0]   d64   [3];
  logic signed [20:0]   d21   [3];
  logic [2:0]           sm_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d64[i]  = 64'(d_i[i]);
      d21[i]  = d64[i][20:0];
      sm_c[i] = (d64[i] < LIM) && (d64[i] > -LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        da_r[i]   <= d_i[i];
        cha_r[i]  <= DW'(chord_i[i]);
        sqa_r[i]  <= 42'(d21[i]) * 42'(d21[i]);
        posa_r[i] <= pos_i[i];
      end
      sma_r <= &sm_c;
    end
  end

  // ---------------- stage b: choose derivative or chord
  logic signed [DW-1:0] vb_r   [3];
  logic signed [C-1:0]  posb_r [3];
  logic                 fbb_r;
  logic [43:0]          sum_b;
  logic                 fb_b;

  assign sum_b = 44'(sqa_r[0]) + 44'(sqa_r[1]) + 44'(sqa_r[2]);
  assign fb_b  = sma_r && (64'(sum_b) <= SHORT_SQ);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        vb_r[i]   <= fb_b ? cha_r[i] : da_r[i];
        posb_r[i] <= posa_r[i];
      end
      fbb_r <= fb_b;
    end
  end

  // ---------------- stage c: magnitudes, signs and largest magnitude
  logic [MW-1:0]       magc_r [3];
  logic [MW-1:0]       mag_c  [3];
  logic [MW-1:0]       mxc_r;
  logic [2:0]          sgnc_r;
  logic signed [C-1:0] posc_r [3];
  logic                fbc_r;
  logic [MW-1:0]       mx_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vb_r[i][DW-1] ? MW'(-vb_r[i]) : MW'(vb_r[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        magc_r[i] <= mag_c[i];
        sgnc_r[i] <= vb_r[i][DW-1];
        posc_r[i] <= posb_r[i];
      end
      mxc_r <= mx_c;
      fbc_r <= fbb_r;
    end
  end

  // ---------------- stage d: leading one of the largest magnitude
  logic [MW-1:0]       magd_r [3];
  logic [2:0]          sgnd_r;
  logic [SHW-1:0]      msbd_r;
  logic                zd_r, fbd_r;
  logic signed [C-1:0] posd_r [3];
  logic [SHW-1:0]      msb_c;

  always_comb begin
    msb_c = '0;
    for (int k = 0; k < MW; k++) begin
      if (mxc_r[k]) msb_c = SHW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magd_r <= magc_r;
      sgnd_r <= sgnc_r;
      msbd_r <= msb_c;
      zd_r   <= (mxc_r == '0);
      fbd_r  <= fbc_r;
      posd_r <= posc_r;
    end
  end

  // ---------------- stage e: shift so the largest lies in [2^30, 2^31)
  logic [NB-1:0] me_c [3];
  logic [SW-1:0] side_e_r;
  logic [SW-1:0] side_e_c;
  logic [63:0]   w_c  [3];
  int            sh_c;

  always_comb begin
    sh_c = int'(msbd_r) - (NB - 1);
    for (int i = 0; i < 3; i++) begin
      w_c[i]  = 64'(magd_r[i]);
      w_c[i]  = (sh_c >= 0) ? (w_c[i] >> sh_c) : (w_c[i] << (-sh_c));
      me_c[i] = w_c[i][NB-1:0];
    end
    side_e_c = '0;
    for (int i = 0; i < 3; i++) begin
      side_e_c[i*NB +: NB]      = me_c[i];
      side_e_c[O_SGN + i]       = sgnd_r[i];
      side_e_c[O_POS + i*C +: C] = posd_r[i];
    end
    side_e_c[O_Z]  = zd_r;
    side_e_c[O_FB] = fbd_r;
  end

  always_ff @(posedge clk) begin
    if (adv) side_e_r <= side_e_c;
  end

  // ---------------- stage f: squares of normalized magnitudes
  logic [2*NB-1:0] sqf_r [3];
  logic [SW-1:0]   side_f_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqf_r[i] <= 62'(side_e_r[i*NB +: NB]) * 62'(side_e_r[i*NB +: NB]);
      end
      side_f_r <= side_e_r;
    end
  end

  // ---------------- square root pipeline, stage zero holds the sum
  logic [63:0]   sq_n_r    [SQ_ST+1];
  logic [63:0]   sq_r_r    [SQ_ST+1];
  logic [SW-1:0] sq_side_r [SQ_ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n_r[0]    <= 64'(sqf_r[0]) + 64'(sqf_r[1]) + 64'(sqf_r[2]);
      sq_r_r[0]    <= '0;
      sq_side_r[0] <= side_f_r;
    end
  end

  for (genvar s = 1; s <= SQ_ST; s++) begin : g_sqrt
    logic [63:0] n_c, r_c, bit_c;
    // restoring square root, one result bit per iteration
    always_comb begin
      n_c   = sq_n_r[s-1];
      r_c   = sq_r_r[s-1];
      bit_c = '0;
      for (int k = 0; k < SQ_PER; k++) begin
        bit_c = 64'd1 << (62 - 2 * ((s - 1) * SQ_PER + k));
        if (n_c >= r_c + bit_c) begin
          n_c = n_c - (r_c + bit_c);
          r_c = (r_c >> 1) + bit_c;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n_r[s]    <= n_c;
        sq_r_r[s]    <= r_c;
        sq_side_r[s] <= sq_side_r[s-1];
      end
    end
  end

  // ---------------- division pipeline, stage zero holds the rounded numerators
  logic [RW-1:0]       dv_rem_r  [DIV_ST+1][3];
  logic [QUO_BITS-1:0] dv_q_r    [DIV_ST+1][3];
  logic [31:0]         dv_len_r  [DIV_ST+1];
  logic [SW-1:0]       dv_side_r [DIV_ST+1];
  logic [31:0]         len_c;

  assign len_c = sq_r_r[SQ_ST][31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= (RW'(sq_side_r[SQ_ST][i*NB +: NB]) << (QUO_BITS - 1))
                          + RW'(len_c >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= len_c;
      dv_side_r[0] <= sq_side_r[SQ_ST];
    end
  end

  for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
    logic [RW-1:0]       rem_c [3];
    logic [QUO_BITS-1:0] q_c   [3];
    logic [RW-1:0]       cmp_c;
    int                  it_c;
    // restoring division, one quotient bit per iteration
    always_comb begin
      cmp_c = '0;
      it_c  = 0;
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = dv_rem_r[s-1][i];
        q_c[i]   = dv_q_r[s-1][i];
        for (int k = 0; k < DIV_PER; k++) begin
          it_c = QUO_BITS - 1 - ((s - 1) * DIV_PER + k);
          if (it_c >= 0) begin
            cmp_c = RW'(dv_len_r[s-1]) << it_c;
            if (rem_c[i] >= cmp_c) begin
              rem_c[i] = rem_c[i] - cmp_c;
              q_c[i]   = q_c[i] | (QUO_BITS'(1) << it_c);
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[s]  <= rem_c;
        dv_q_r[s]    <= q_c;
        dv_len_r[s]  <= dv_len_r[s-1];
        dv_side_r[s] <= dv_side_r[s-1];
      end
    end
  end

  // ---------------- output stage: clamp, apply sign, zero output for a zero vector
  logic [SW-1:0]       side_o;
  logic [QUO_BITS-1:0] qc_c [3];

  assign side_o = dv_side_r[DIV_ST];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_c[i] = (dv_q_r[DIV_ST][i] > QUO_BITS'(DIR_ONE)) ? QUO_BITS'(DIR_ONE)
                                                          : dv_q_r[DIV_ST][i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pos_o[i] <= side_o[O_POS + i*C +: C];
        if (side_o[O_Z]) dir_o[i] <= '0;
        else if (side_o[O_SGN + i]) dir_o[i] <= -DIR_BITS'(qc_c[i]);
        else dir_o[i] <= DIR_BITS'(qc_c[i]);
      end
      fb_o <= side_o[O_FB];
    end
  end

  // valid bits: stages a..f, square root, division and output
  localparam int NV = 6 + 1 + SQ_ST + 1 + DIV_ST + 1;
  logic [NV-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], ctl.vld};
    end
  end

  assign vld_o = vld_r[NV-1];

endmodule

// ===== rtl/cubic_bezier_point_tangent_core.sv =====
// cubic_bezier_point_tangent_core: top level, control point registers, apb port,
// three axis interpolators and the tangent normalizer; depends on cbpt_pkg
`timescale 1ns / 1ps
//
// usage
//   program the four control points over the apb port at byte addresses 0, 8,
//   16 and 24 (x in the low coordinate field, then y, then z); program only
//   while no request is in flight. then send requests on the in_ channel, one
//   curve parameter each; every request gives exactly one result on out_.
// timing
//   one request is taken every cycle while in_stall is low. the depth is set
//   by the square root (two result bits per stage) and the per-lane divider
//   (two quotient bits per stage).
// stall
//   the whole pipeline advances together; while out_valid is high and
//   out_stall is asserted it holds, the result stays on out_, and in_stall is
//   raised. no result is lost or repeated.
// reset
//   synchronous active-low rst_n clears all valid bits and the control points.
//
module cubic_bezier_point_tangent_core #(
  parameter int COORD_BITS      = 21,
  parameter int COORD_FRAC_BITS = 8,
  parameter int PARAM_BITS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbpt_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [cbpt_pkg::DATA_BITS-1:0]       pwdata,
  output logic [cbpt_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [PARAM_BITS:0]                  in_curve_param,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COORD_BITS-1:0]         out_pos_x,
  output logic signed [COORD_BITS-1:0]         out_pos_y,
  output logic signed [COORD_BITS-1:0]         out_pos_z,
  output logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_x,
  output logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_y,
  output logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_z,
  output logic                                 out_used_fallback
);
  import cbpt_pkg::*;

  localparam int C = COORD_BITS;

  logic [PT_BITS-1:0] start_point_r, first_control_r, second_control_r, end_point_r;
  logic [1:0]         reg_idx;

  // register writes on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_point_r    <= '0;
      first_control_r  <= '0;
      second_control_r <= '0;
      end_point_r      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_START: start_point_r    <= pwdata[PT_BITS-1:0];
        REG_CTRL1: first_control_r  <= pwdata[PT_BITS-1:0];
        REG_CTRL2: second_control_r <= pwdata[PT_BITS-1:0];
        REG_END:   end_point_r      <= pwdata[PT_BITS-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_START: prdata = DATA_BITS'(start_point_r);
      REG_CTRL1: prdata = DATA_BITS'(first_control_r);
      REG_CTRL2: prdata = DATA_BITS'(second_control_r);
      REG_END:   prdata = DATA_BITS'(end_point_r);
    endcase
  end

  // whole pipeline advances unless a finished result is held
  pipe_ctl_t ctl_in, ctl_nrm;
  logic      adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign ctl_in   = '{adv: adv, vld: in_valid};

  // coordinate fields, zero above the register width
  logic [127:0] ext0, ext1, ext2, ext3;
  assign ext0 = 128'(start_point_r);
  assign ext1 = 128'(first_control_r);
  assign ext2 = 128'(second_control_r);
  assign ext3 = 128'(end_point_r);

  logic signed [C+2:0] d_w     [3];
  logic signed [C:0]   chord_w [3];
  logic signed [C-1:0] pos_w   [3];
  logic signed [C-1:0] pos_o   [3];
  logic signed [DIR_BITS-1:0] dir_o [3];
  logic [2:0]          ax_vld;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    cbpt_casteljau #(.C(C), .P(PARAM_BITS)) u_axis (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl_in),
      .t_i     (in_curve_param),
      .p0_i    (ext0[g*C +: C]),
      .p1_i    (ext1[g*C +: C]),
      .p2_i    (ext2[g*C +: C]),
      .p3_i    (ext3[g*C +: C]),
      .vld_o   (ax_vld[g]),
      .pos_o   (pos_w[g]),
      .d_o     (d_w[g]),
      .chord_o (chord_w[g])
    );
  end

  assign ctl_nrm = '{adv: adv, vld: ax_vld[0] & ax_vld[1] & ax_vld[2]};

  cbpt_norm #(.C(C), .F(COORD_FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_nrm),
    .d_i     (d_w),
    .chord_i (chord_w),
    .pos_i   (pos_w),
    .vld_o   (out_valid),
    .pos_o   (pos_o),
    .dir_o   (dir_o),
    .fb_o    (out_used_fallback)
  );

  assign out_pos_x = pos_o[0];
  assign out_pos_y = pos_o[1];
  assign out_pos_z = pos_o[2];
  assign out_dir_x = dir_o[0];
  assign out_dir_y = dir_o[1];
  assign out_dir_z = dir_o[2];

endmodule

// ===== rtl/cbpt_checker.sv =====
// cbpt_checker: port-level assertions for the cubic bezier core, bound to the top
// depends on cbpt_pkg and cubic_bezier_point_tangent_core
`timescale 1ns / 1ps

module cbpt_checker #(
  parameter int COORD_BITS      = 21
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 pready,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [COORD_BITS-1:0]         out_pos_x,
  input logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_x,
  input logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_y,
  input logic signed [cbpt_pkg::DIR_BITS-1:0] out_dir_z,
  input logic                                 out_used_fallback
);
  import cbpt_pkg::*;

  localparam logic signed [DIR_BITS-1:0] DMAX = DIR_BITS'(DIR_ONE);

  // a held result stays valid and keeps its x position and x tangent
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_dir_x))
    else $error("held result changed");

  // requests are refused only while a result is held
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request refused without output back-pressure");

  // a long derivative always gives a nonzero tangent
  a_dir_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_used_fallback |-> (out_dir_x != 0 || out_dir_y != 0 || out_dir_z != 0))
    else $error("zero tangent without fallback");

  // tangent components stay within unit range
  a_dir_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_x <= DMAX && out_dir_x >= -DMAX &&
                  out_dir_y <= DMAX && out_dir_y >= -DMAX &&
                  out_dir_z <= DMAX && out_dir_z >= -DMAX)
    else $error("tangent component out of range");

  // apb port never waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid || !in_valid |-> pready)
    else $error("pready dropped");

endmodule

bind cubic_bezier_point_tangent_core cbpt_checker #(
  .COORD_BITS      (COORD_BITS)
) u_cbpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .pready            (pready),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pos_x         (out_pos_x),
  .out_dir_x         (out_dir_x),
  .out_dir_y         (out_dir_y),
  .out_dir_z         (out_dir_z),
  .out_used_fallback (out_used_fallback)
);

// ===== tb/cbpt_checker.sv =====
// cbpt_scoreboard: watches the config port and both channels of the bezier core,
// predicts each point and unit tangent, and compares them; depends on cbpt_pkg
`timescale 1ns / 1ps

module cbpt_scoreboard (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [cbpt_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [cbpt_pkg::DATA_BITS-1:0]     pwdata,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [16:0]                        in_curve_param,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [20:0]                 out_pos_x,
  input  logic signed [20:0]                 out_pos_y,
  input  logic signed [20:0]                 out_pos_z,
  input  logic signed [15:0]                 out_dir_x,
  input  logic signed [15:0]                 out_dir_y,
  input  logic signed [15:0]                 out_dir_z,
  input  logic                               out_used_fallback,
  output int                                 fail_count,
  output int                                 pending
);
  import cbpt_pkg::*;

  typedef struct {
    logic signed [20:0] pos [3];
    logic signed [15:0] dir [3];
    logic               fallback;
  } curve_sample_t;

  logic [PT_BITS-1:0] ctrl_pts [4];
  curve_sample_t      expected_samples [$];

  // floor square root of a 64-bit value, digit by digit
  function automatic bit [63:0] root_floor(bit [63:0] n);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale to a unit vector in q1.14
  function automatic void unit_dir(input longint v [3], output logic signed [15:0] o [3]);
    bit [63:0] mag [3];
    bit [63:0] mx;
    bit [63:0] sum;
    bit [63:0] len;
    bit [63:0] q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * DIR_ONE + len / 2) / len;
      if (q > DIR_ONE) q = DIR_ONE;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint interp(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t + 32768;
    return a + (prod >>> 16);
  endfunction

  // de casteljau point plus derivative or chord direction
  function automatic curve_sample_t eval_curve(logic [16:0] tp);
    curve_sample_t s;
    longint t, p0, p1, p2, p3, a0, a1, a2, b0, b1, p;
    longint d [3];
    longint chord [3];
    logic   short_d;
    longint sq;
    t = tp > 17'd65536 ? 65536 : longint'(tp);
    short_d = 1;
    sq = 0;
    for (int c = 0; c < 3; c++) begin
      p0 = longint'($signed(ctrl_pts[0][c*21 +: 21]));
      p1 = longint'($signed(ctrl_pts[1][c*21 +: 21]));
      p2 = longint'($signed(ctrl_pts[2][c*21 +: 21]));
      p3 = longint'($signed(ctrl_pts[3][c*21 +: 21]));
      a0 = interp(p0, p1, t);
      a1 = interp(p1, p2, t);
      a2 = interp(p2, p3, t);
      b0 = interp(a0, a1, t);
      b1 = interp(a1, a2, t);
      p = interp(b0, b1, t);
      if (p > 1048575) p = 1048575;
      if (p < -1048576) p = -1048576;
      s.pos[c] = p;
      d[c] = 3 * (b1 - b0);
      chord[c] = p3 - p0;
      if (d[c] >= (64'sd1 << SMALL_LOG) || d[c] <= -(64'sd1 << SMALL_LOG)) short_d = 0;
      else sq = sq + d[c] * d[c];
    end
    s.fallback = short_d && sq <= 6;
    if (s.fallback) unit_dir(chord, s.dir);
    else unit_dir(d, s.dir);
    return s;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // track config writes, predict on accepted requests, check accepted results
  always @(posedge clk) begin
    curve_sample_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) ctrl_pts[i] = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:3] <= REG_END)
        ctrl_pts[paddr[4:3]] = pwdata[PT_BITS-1:0];
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("mismatch: result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_pos_x !== want.pos[0]) report("pos_x", out_pos_x, want.pos[0]);
          if (out_pos_y !== want.pos[1]) report("pos_y", out_pos_y, want.pos[1]);
          if (out_pos_z !== want.pos[2]) report("pos_z", out_pos_z, want.pos[2]);
          if (out_dir_x !== want.dir[0]) report("dir_x", out_dir_x, want.dir[0]);
          if (out_dir_y !== want.dir[1]) report("dir_y", out_dir_y, want.dir[1]);
          if (out_dir_z !== want.dir[2]) report("dir_z", out_dir_z, want.dir[2]);
          if (out_used_fallback !== want.fallback)
            report("used_fallback", out_used_fallback, want.fallback);
        end
      end
      if (in_valid && !in_stall)
        expected_samples.insert(expected_samples.size(), eval_curve(in_curve_param));
    end
    pending = expected_samples.size();
  end

  initial fail_count = 0;

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for cubic_bezier_point_tangent_core
// depends on cbpt_pkg, the core and cbpt_scoreboard
`timescale 1ns / 1ps

module tb;
  import cbpt_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid = 0;
  logic                  in_stall;
  logic [16:0]           in_curve_param = '0;
  logic                  out_valid;
  logic                  out_stall = 0;
  logic signed [20:0]    out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0]    out_dir_x, out_dir_y, out_dir_z;
  logic                  out_used_fallback;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  bit                    steady = 0;

  always #5 clk = ~clk;

  cubic_bezier_point_tangent_core dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_curve_param,
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_dir_x, .out_dir_y, .out_dir_z, .out_used_fallback
  );

  cbpt_scoreboard u_scoreboard (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_curve_param,
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_dir_x, .out_dir_y, .out_dir_z, .out_used_fallback,
    .fail_count, .pending
  );

  // result side backpressure
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 14);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_point(logic [1:0] idx, logic [63:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // pack three coordinates into one control point word
  function automatic logic [63:0] pack_pt(logic [20:0] x, logic [20:0] y, logic [20:0] z);
    return {1'b0, z, y, x};
  endfunction

  task automatic set_curve(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
    write_point(REG_START, a);
    write_point(REG_CTRL1, b);
    write_point(REG_CTRL2, c);
    write_point(REG_END, d);
    @(posedge clk);
  endtask

  task automatic send_param(logic [16:0] t);
    int gap;
    if (!steady && $urandom_range(99) < 14) begin
      gap = $urandom_range(4, 1);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_curve_param <= t;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_coord(bit near);
    return near ? 21'($signed($urandom_range(6)) - 3) : 21'($urandom);
  endfunction

  function automatic logic [16:0] rand_param;
    case ($urandom_range(9))
      0: return 17'($urandom);
      1: return $urandom_range(3) == 0 ? 17'd0 : 17'd65536;
      2: return 17'($urandom_range(7));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    logic [63:0] pts [4];
    bit near;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset state: every point at the origin, zero chord fallback
    send_param(17'd0);
    send_param(17'd65536);
    drain();

    // extreme corners, parameter edges and values past one
    set_curve(pack_pt(21'h100000, 21'h0FFFFF, 21'h100000),
              pack_pt(21'h0FFFFF, 21'h100000, 21'h0FFFFF),
              pack_pt(21'h100000, 21'h100000, 21'h0FFFFF),
              {1'b1, 63'h7FFF_FFFF_FFFF_FFFF});
    foreach (pts[i]) pts[i] = 0;
    send_param(17'd0);
    send_param(17'd1);
    send_param(17'd32768);
    send_param(17'd65535);
    send_param(17'd65536);
    send_param(17'd65537);
    send_param(17'h1FFFF);
    send_param(17'h15555);
    send_param(17'h0AAAA);
    drain();

    // coincident endpoints with control points: short derivative at t = 0 and 1
    set_curve(pack_pt(21'd100, -21'd50, 21'd7), pack_pt(21'd100, -21'd50, 21'd7),
              pack_pt(21'd900, 21'd300, -21'd20), pack_pt(21'd900, 21'd300, -21'd20));
    send_param(17'd0);
    send_param(17'd65536);
    send_param(17'd20000);
    drain();
    // all points equal and not zero: zero chord with fallback
    set_curve(pack_pt(21'd5, 21'd5, 21'd5), pack_pt(21'd5, 21'd5, 21'd5),
              pack_pt(21'd5, 21'd5, 21'd5), pack_pt(21'd5, 21'd5, 21'd5));
    send_param(17'd0);
    send_param(17'd40000);
    // closed loop: derivative can vanish while chord is zero
    drain();
    set_curve(pack_pt(21'd0, 21'd0, 21'd0), pack_pt(21'd2, 21'd0, 21'd1),
              pack_pt(-21'd2, 21'd0, -21'd1), pack_pt(21'd0, 21'd0, 21'd0));
    send_param(17'd32768);
    send_param(17'd16384);
    send_param(17'd0);
    drain();

    // random phases: each gets a fresh curve and a batch of parameters
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph == 4);
      near = ($urandom_range(2) == 0);
      foreach (pts[i]) begin
        if ($urandom_range(3) == 0) pts[i] = {$urandom, $urandom};
        else pts[i] = pack_pt(rand_coord(near), rand_coord(near), rand_coord(near));
      end
      if (ph == 7) begin
        pts[1] = pts[0];
        pts[3] = pts[2];
      end
      set_curve(pts[0], pts[1], pts[2], pts[3]);
      for (int k = 0; k < 83; k++) send_param(rand_param());
      drain();
    end
    steady = 0;

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
